// File: hdl/mapped_region_table_top_macros.svh
// Assertion macros for the mapped region table.
// Relies on clk and rst being visible in the module that asserts.
`ifndef MAPPED_REGION_TABLE_TOP_MACROS_SVH
`define MAPPED_REGION_TABLE_TOP_MACROS_SVH

// clocked check, muted while reset is high
`define MRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same-cycle implication
`define MRT_ASSERT_IMPL(lbl, ante, cons, msg) \
  `MRT_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define MRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  `MRT_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: hdl/mrt_pkg.sv
// Shared types and constants for the mapped region table.
// No dependencies.
package mrt_pkg;

  localparam int ADDR_BITS      = 38;
  localparam int OFS_BITS       = 32;
  localparam int ENTRIES_DEF    = 16;
  localparam int PAGE_BITS_DEF  = 12;

  localparam logic [ADDR_BITS-1:0] REGION_TOP_RST = 38'h3F_FFFF_E000;

  // request kinds
  localparam logic [1:0] KIND_MAP    = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_UNMAP  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_ARG = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_NO_REG  = 3'd3;
  localparam logic [2:0] ST_HOLE    = 3'd4;

  typedef struct packed {
    logic [1:0]           kind;
    logic [ADDR_BITS-1:0] address;
    logic [ADDR_BITS-1:0] length;
    logic [2:0]           protection;
    logic [1:0]           map_flags;
    logic [3:0]           file_handle;
    logic                 file_readable;
    logic                 file_writable;
    logic [OFS_BITS-1:0]  start_offset;
  } req_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [ADDR_BITS-1:0] region_start;
    logic [OFS_BITS-1:0]  page_file_offset;
    logic [3:0]           region_file;
    logic [2:0]           page_permission;
    logic [ADDR_BITS-1:0] drop_start;
    logic [ADDR_BITS-1:0] drop_length;
    logic                 file_released;
  } rsp_t;

  // one table entry as held in the RAM
  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] size;
    logic [2:0]           protection;
    logic [1:0]           flags;
    logic [3:0]           file;
    logic [OFS_BITS-1:0]  offset;
  } entry_t;

endpackage

// File: hdl/mrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/mapped_region_table_top.sv
// Mapped region table (map, lookup, unmap); needs mrt_pkg, mrt_ram and the macros header.
// From start to done: the registered RAM read, one compare per entry through the single read
// port, then a calc state and a result state.
// One transaction at a time; busy falls as done rises, so a new request is taken only once
// the last one is through. done strobes the result for one cycle; the receiver cannot stall.
// Sync reset clears every valid bit and restores region_top; RAM contents are kept.
`include "mapped_region_table_top_macros.svh"

module mapped_region_table_top import mrt_pkg::*; #(
  parameter int ENTRIES   = ENTRIES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // transaction request
  input  logic                 start,
  input  req_t                 req,
  output logic                 busy,
  // result, valid for the single cycle done is high
  output logic                 done,
  output rsp_t                 rsp,
  // region_top register
  input  logic                 cfg_we,
  input  logic [ADDR_BITS-1:0] cfg_wdata
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int EW    = $bits(entry_t);

  // page masks at address width, address width plus carry, and offset width
  localparam logic [ADDR_BITS-1:0] PMASK   = ADDR_BITS'((64'd1 << PAGE_BITS) - 64'd1);
  localparam logic [ADDR_BITS:0]   PMASK_X = {1'b0, PMASK};
  localparam logic [OFS_BITS-1:0]  PMASK_O = OFS_BITS'((64'd1 << PAGE_BITS) - 64'd1);
  localparam logic [IDX_W:0]       N_ENT   = (IDX_W+1)'(ENTRIES);
  localparam logic [IDX_W-1:0]     LAST    = IDX_W'(ENTRIES - 1);

  // Flow: IDLE -> SCAN (read every entry, one per cycle, pipelined over the
  // registered RAM read) -> CALC (wide compares and sums on the hit entry,
  // and the map fit check) -> DONE (result, write-back and valid-bit update).
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_CALC, S_DONE} state_t;

  state_t               state;
  logic [ADDR_BITS-1:0] region_top;
  logic [ENTRIES-1:0]   entry_valid;

  // latched transaction
  req_t                 req_r;
  logic                 bad_r;       // argument check failed
  logic [ADDR_BITS:0]   msize_r;     // map length rounded up to pages

  // scan
  logic [IDX_W:0]       rd_cnt;
  logic                 chk_vld;
  logic [IDX_W-1:0]     chk_idx;
  logic                 found;
  logic [IDX_W-1:0]     hit_idx;
  entry_t               hit_e;
  logic [ADDR_BITS:0]   hit_end;
  logic                 slot_found;
  logic [IDX_W-1:0]     slot_idx;
  logic [ADDR_BITS-1:0] top_r;

  // calc results
  logic [ADDR_BITS:0]   end_r;
  logic                 hole_r;
  logic                 front_r;
  logic                 a_gt_s_r;
  logic [OFS_BITS-1:0]  cut_r;
  logic [ADDR_BITS-1:0] new_size_r;
  logic [ADDR_BITS-1:0] diff_r;
  logic [ADDR_BITS-1:0] aligned_r;
  logic                 fit_r;

  // RAM ports
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  entry_t               ram_wdata;
  logic                 ram_re;
  entry_t               ram_rdata;

  mrt_ram #(
    .WIDTH (EW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_cnt[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign busy   = (state != S_IDLE);
  assign ram_re = (state == S_SCAN) && (rd_cnt < N_ENT);

  // ---------------------------------------------------------------------------
  // Accept-time argument checks (map and unmap reject without writing the table)
  // ---------------------------------------------------------------------------
  logic [ADDR_BITS:0] in_msize;
  logic               in_bad;

  always_comb begin
    in_msize = ({1'b0, req.length} + PMASK_X) & ~PMASK_X;
    unique case (req.kind)
      KIND_MAP: begin
        in_bad = (req.length == '0) ||
                 (!req.file_readable && req.protection[0]) ||
                 (!req.file_writable && req.protection[1] && !req.map_flags[1]) ||
                 in_msize[ADDR_BITS];
      end
      KIND_LOOKUP: in_bad = 1'b0;
      KIND_UNMAP:  in_bad = (req.length == '0);
      default:     in_bad = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Scan compare on the entry just read
  // ---------------------------------------------------------------------------
  logic               cur_valid;
  logic [ADDR_BITS:0] cur_end;
  logic               cur_hit;

  always_comb begin
    cur_valid = entry_valid[chk_idx];
    cur_end   = {1'b0, ram_rdata.start} + {1'b0, ram_rdata.size};
    cur_hit   = cur_valid && (req_r.address >= ram_rdata.start) &&
                ({1'b0, req_r.address} < cur_end);
  end

  // ---------------------------------------------------------------------------
  // Calc stage: unmap geometry, lookup distance, map fit
  // ---------------------------------------------------------------------------
  logic [ADDR_BITS:0] end_w;

  always_comb begin
    end_w = {1'b0, req_r.address} + {1'b0, req_r.length};
  end

  // ---------------------------------------------------------------------------
  // Done stage: result selection and write-back
  // ---------------------------------------------------------------------------
  logic [PAGE_BITS-1:0] adv;
  logic [ADDR_BITS-1:0] adv_x;
  logic                 map_ok;
  logic                 unmap_ok;
  logic                 freed;
  rsp_t                 rsp_next;
  entry_t               upd_e;

  always_comb begin
    adv   = a_gt_s_r ? (~req_r.address[PAGE_BITS-1:0] + PAGE_BITS'(1)) : '0;
    adv_x = ADDR_BITS'(adv);
    map_ok   = 1'b0;
    unmap_ok = 1'b0;
    freed    = (new_size_r == '0);
    rsp_next = '0;

    // unmap update of the hit entry
    upd_e        = hit_e;
    upd_e.size   = new_size_r;
    if (front_r) begin
      upd_e.start  = end_r[ADDR_BITS-1:0];
      upd_e.offset = hit_e.offset + cut_r;
    end

    priority if (bad_r) begin
      rsp_next.status = ST_BAD_ARG;
    end else if (req_r.kind == KIND_MAP) begin
      priority if (!slot_found) begin
        rsp_next.status = ST_FULL;
      end else if (!fit_r) begin
        rsp_next.status = ST_BAD_ARG;
      end else begin
        map_ok                = 1'b1;
        rsp_next.status       = ST_OK;
        rsp_next.region_start = top_r - msize_r[ADDR_BITS-1:0];
      end
    end else if (!found) begin
      rsp_next.status = ST_NO_REG;
    end else if (req_r.kind == KIND_LOOKUP) begin
      rsp_next.status           = ST_OK;
      rsp_next.page_file_offset = hit_e.offset + (diff_r[OFS_BITS-1:0] & ~PMASK_O);
      rsp_next.region_file      = hit_e.file;
      rsp_next.page_permission  = hit_e.protection;
    end else if (hole_r) begin
      rsp_next.status = ST_HOLE;
    end else begin
      unmap_ok               = 1'b1;
      rsp_next.status        = ST_OK;
      rsp_next.region_file   = hit_e.file;
      rsp_next.drop_start    = aligned_r;
      rsp_next.drop_length   = (req_r.length > adv_x) ? (req_r.length - adv_x) : '0;
      rsp_next.file_released = freed;
    end

    ram_we    = (state == S_DONE) && (map_ok || unmap_ok);
    ram_waddr = map_ok ? slot_idx : hit_idx;
    if (map_ok) begin
      ram_wdata.start      = rsp_next.region_start;
      ram_wdata.size       = msize_r[ADDR_BITS-1:0];
      ram_wdata.protection = req_r.protection;
      ram_wdata.flags      = req_r.map_flags;
      ram_wdata.file       = req_r.file_handle;
      ram_wdata.offset     = req_r.start_offset;
    end else begin
      ram_wdata = upd_e;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      region_top  <= REGION_TOP_RST;
      entry_valid <= '0;
      done        <= 1'b0;
      chk_vld     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        region_top <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state      <= S_SCAN;
            req_r      <= req;
            bad_r      <= in_bad;
            msize_r    <= in_msize;
            rd_cnt     <= '0;
            chk_vld    <= 1'b0;
            found      <= 1'b0;
            slot_found <= 1'b0;
            top_r      <= region_top;
          end
        end
        S_SCAN: begin
          if (rd_cnt < N_ENT) begin
            rd_cnt  <= rd_cnt + (IDX_W+1)'(1);
            chk_vld <= 1'b1;
            chk_idx <= rd_cnt[IDX_W-1:0];
          end else begin
            chk_vld <= 1'b0;
          end
          if (chk_vld) begin
            // first free slot and lowest placement top, for map
            if (!cur_valid) begin
              if (!slot_found) begin
                slot_found <= 1'b1;
                slot_idx   <= chk_idx;
              end
            end else if (ram_rdata.start < top_r) begin
              top_r <= ram_rdata.start & ~PMASK;
            end
            // first region holding the address, for lookup and unmap
            if (cur_hit && !found) begin
              found   <= 1'b1;
              hit_idx <= chk_idx;
              hit_e   <= ram_rdata;
              hit_end <= cur_end;
            end
            if (chk_idx == LAST) begin
              state <= S_CALC;
            end
          end
        end
        S_CALC: begin
          state      <= S_DONE;
          end_r      <= end_w;
          a_gt_s_r   <= (req_r.address > hit_e.start);
          hole_r     <= (req_r.address > hit_e.start) && (end_w < hit_end);
          front_r    <= (req_r.address <= hit_e.start) && (end_w > {1'b0, hit_e.start});
          cut_r      <= end_w[OFS_BITS-1:0] - hit_e.start[OFS_BITS-1:0];
          new_size_r <= (hit_e.size > req_r.length) ? (hit_e.size - req_r.length) : '0;
          diff_r     <= req_r.address - hit_e.start;
          aligned_r  <= (req_r.address > hit_e.start) ?
                        ((req_r.address + PMASK) & ~PMASK) : req_r.address;
          fit_r      <= (msize_r <= {1'b0, top_r});
        end
        S_DONE: begin
          state <= S_IDLE;
          done  <= 1'b1;
          rsp   <= rsp_next;
          if (map_ok) begin
            entry_valid[slot_idx] <= 1'b1;
          end else if (unmap_ok && freed) begin
            entry_valid[hit_idx] <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `MRT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction not busy")
  `MRT_ASSERT_IMPL(a_done_idle, done, !busy && $past(state == S_DONE), "done outside result slot")
  `MRT_ASSERT_IMPL(a_status_code, done, rsp.status <= ST_HOLE, "status code out of range")
  `MRT_ASSERT_IMPL(a_release_ok, done && rsp.file_released, rsp.status == ST_OK, "release on failed unmap")

endmodule
